FILE: design/bccc_pkg.sv
`default_nettype none

package bccc_pkg;

   localparam int SOURCE_BITS = 8;
   localparam int TIMER_BITS = 16;
   localparam int COUNT_BITS = 8;
   localparam int CLICK_BITS = 2;
   localparam int CSR_INDEX_BITS = 4;
   localparam int CSR_DATA_BITS = 16;

   localparam logic [TIMER_BITS-1:0] TIMEOUT_RESET = 16'd500;
   localparam logic [COUNT_BITS-1:0] COUNT_RESET = 8'd1;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_CLICK_TIMEOUT = 4'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SOURCE_COUNT = 4'd1;

   localparam logic [1:0] CMD_NONE = 2'd0;
   localparam logic [1:0] CMD_INFO = 2'd1;
   localparam logic [1:0] CMD_START = 2'd2;
   localparam logic [1:0] CMD_CANCEL = 2'd3;

   localparam logic [CLICK_BITS-1:0] CLICKS_ONE = 2'd1;
   localparam logic [CLICK_BITS-1:0] CLICKS_TWO = 2'd2;
   localparam logic [CLICK_BITS-1:0] CLICKS_MAX = 2'd3;

   typedef struct packed {
      logic                  prev_level;
      logic                  enter_level;
      logic                  next_level;
      logic [TIMER_BITS-1:0] elapsed_ms;
      logic                  print_begin;
      logic                  print_end;
   } req_word_type;

   typedef struct packed {
      logic [1:0]             command;
      logic [SOURCE_BITS-1:0] source_index;
      logic                   printing;
   } rsp_word_type;

   typedef struct packed {
      logic                      write;
      logic [CSR_INDEX_BITS-1:0] index;
      logic [CSR_DATA_BITS-1:0]  data;
   } csr_write_type;

endpackage

`default_nettype wire

FILE: design/bccc_core.sv
`default_nettype none

module bccc_core (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire bccc_pkg::csr_write_type csr,
   input  wire logic                   step,
   input  wire bccc_pkg::req_word_type req_word,
   output bccc_pkg::rsp_word_type      rsp_word
);

   logic [bccc_pkg::TIMER_BITS-1:0]  timeout_ff;
   logic [bccc_pkg::COUNT_BITS-1:0]  count_ff;
   logic [2:0]                       pressed_ff;
   logic [2:0]                       pressed_in;
   logic [bccc_pkg::TIMER_BITS-1:0]  timer_ff;
   logic [bccc_pkg::TIMER_BITS-1:0]  timer_in;
   logic [bccc_pkg::CLICK_BITS-1:0]  clicks_ff;
   logic [bccc_pkg::CLICK_BITS-1:0]  clicks_in;
   logic [bccc_pkg::SOURCE_BITS-1:0] source_ff;
   logic [bccc_pkg::SOURCE_BITS-1:0] source_in;
   logic                             printing_ff;
   logic                             printing_in;

   logic [2:0]                       released;
   logic [bccc_pkg::TIMER_BITS-1:0]  timer_dec;
   logic                             done;
   logic [bccc_pkg::COUNT_BITS-1:0]  count;
   logic [bccc_pkg::SOURCE_BITS-1:0] after_prev;
   logic [bccc_pkg::SOURCE_BITS:0]   next_sum;
   logic [1:0]                       command;

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= bccc_pkg::TIMEOUT_RESET;
         count_ff <= bccc_pkg::COUNT_RESET;
      end else if (csr.write) begin
         if (csr.index == bccc_pkg::CSR_CLICK_TIMEOUT) begin
            timeout_ff <= csr.data[bccc_pkg::TIMER_BITS-1:0];
         end
         if (csr.index == bccc_pkg::CSR_SOURCE_COUNT) begin
            count_ff <= csr.data[bccc_pkg::COUNT_BITS-1:0];
         end
      end
   end

   always_comb begin
      printing_in = printing_ff;
      if (req_word.print_begin) begin
         printing_in = 1'b1;
      end
      if (req_word.print_end) begin
         printing_in = 1'b0;
      end

      pressed_in = {~req_word.next_level, ~req_word.enter_level, ~req_word.prev_level};
      released = pressed_ff & ~pressed_in;

      timer_dec = (timer_ff > req_word.elapsed_ms) ? timer_ff - req_word.elapsed_ms
                                                   : '0;
      timer_in = timer_dec;
      clicks_in = clicks_ff;
      done = 1'b0;
      if (released[1]) begin
         if (clicks_ff != bccc_pkg::CLICKS_MAX) begin
            clicks_in = clicks_ff + 1'b1;
         end
         timer_in = timeout_ff;
      end else if (timer_dec == '0 && !pressed_in[1]) begin
         done = 1'b1;
      end

      count = (count_ff == '0) ? bccc_pkg::COUNT_RESET : count_ff;
      source_in = source_ff;
      command = bccc_pkg::CMD_NONE;
      if (!printing_in) begin
         after_prev = source_ff;
         if (released[0]) begin
            after_prev = (source_ff == '0) ? count - 1'b1 : source_ff - 1'b1;
         end
         source_in = after_prev;
         next_sum = {1'b0, after_prev} + 1'b1;
         if (released[2]) begin
            source_in = (next_sum >= {1'b0, count}) ? '0
                                                    : next_sum[bccc_pkg::SOURCE_BITS-1:0];
         end
         if (done && clicks_ff == bccc_pkg::CLICKS_ONE) begin
            command = bccc_pkg::CMD_INFO;
         end
         if (done && clicks_ff == bccc_pkg::CLICKS_TWO) begin
            command = bccc_pkg::CMD_START;
         end
      end else begin
         after_prev = source_ff;
         next_sum = '0;
         if (done && clicks_ff == bccc_pkg::CLICKS_TWO) begin
            command = bccc_pkg::CMD_CANCEL;
         end
      end

      if (done) begin
         clicks_in = '0;
         timer_in = '0;
      end

      rsp_word.command = command;
      rsp_word.source_index = source_in;
      rsp_word.printing = printing_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pressed_ff <= '0;
         timer_ff <= '0;
         clicks_ff <= '0;
         source_ff <= '0;
         printing_ff <= 1'b0;
      end else if (step) begin
         pressed_ff <= pressed_in;
         timer_ff <= timer_in;
         clicks_ff <= clicks_in;
         source_ff <= source_in;
         printing_ff <= printing_in;
      end
   end

endmodule

`default_nettype wire

FILE: design/button_click_command_controller_unit.sv
// channel | direction | handshake             | payload
// req     | in        | req_valid / req_ready | req_word  (bccc_pkg::req_word_type)
// rsp     | out       | rsp_valid / rsp_ready | rsp_word  (bccc_pkg::rsp_word_type)
// csr     | in        | csr_valid / csr_ready | csr_index, csr_data
//
// One poll word per cycle while rsp is not stalled; an accepted poll passes the input
// register and then the result register before rsp_valid rises.
// The input register holds the poll, the state update and result are computed
// in one pass into the result register.
// Synchronous reset restores the timeout to 500 ms and the source count to 1.
// A stalled rsp backs up into the input register and then drops req_ready.
// csr_ready is always high.
`default_nettype none

module button_click_command_controller_unit (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_valid,
   output logic                                        req_ready,
   input  wire bccc_pkg::req_word_type                 req_word,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_ready,
   output bccc_pkg::rsp_word_type                      rsp_word,
   input  wire logic                                   csr_valid,
   output logic                                        csr_ready,
   input  wire logic [bccc_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  wire logic [bccc_pkg::CSR_DATA_BITS-1:0]     csr_data
);

   logic                   stage_valid_ff;
   logic                   stage_valid_in;
   bccc_pkg::req_word_type stage_word_ff;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   bccc_pkg::rsp_word_type rsp_word_ff;
   bccc_pkg::rsp_word_type result;
   bccc_pkg::csr_write_type csr;
   logic                   advance;
   logic                   step;

   assign csr_ready = 1'b1;
   assign csr.write = csr_valid;
   assign csr.index = csr_index;
   assign csr.data = csr_data;

   assign advance = !rsp_valid_ff || rsp_ready;
   assign step = stage_valid_ff && advance;
   assign req_ready = !stage_valid_ff || advance;

   assign stage_valid_in = (req_valid && req_ready) || (stage_valid_ff && !advance);
   assign rsp_valid_in = advance ? stage_valid_ff : rsp_valid_ff;

   bccc_core u_core (
      .clock    (clock),
      .reset    (reset),
      .csr      (csr),
      .step     (step),
      .req_word (stage_word_ff),
      .rsp_word (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         stage_word_ff <= req_word;
      end
      if (step) begin
         rsp_word_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word = rsp_word_ff;

`ifndef SYNTHESIS
   a_cancel_only_printing: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.command == bccc_pkg::CMD_CANCEL |-> rsp_word.printing)
      else $error("cancel issued while not printing");

   a_start_info_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_word.command == bccc_pkg::CMD_INFO
                    || rsp_word.command == bccc_pkg::CMD_START) |-> !rsp_word.printing)
      else $error("info or start issued while printing");

   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> stage_valid_ff && rsp_valid_ff && !rsp_ready)
      else $error("req_ready low without a full pipe");

   a_step_fills_rsp: assert property (@(posedge clock) disable iff (reset)
      step |=> rsp_valid)
      else $error("computed word not presented");
`endif

endmodule

`default_nettype wire

FILE: verif/button_click_command_controller_unit_tb.sv
`timescale 1ns / 1ps

module button_click_command_controller_unit_tb;
   import bccc_pkg::*;

   localparam int QUIET_LIMIT = 2000;
   localparam int LONG_HOLD = 120;
   localparam int HOLD_AT = 150;
   localparam int PRINT_CAP = 40;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_word_type req_word = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_word_type rsp_word;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0] csr_data = '0;

   req_word_type poll_queue[$];
   rsp_word_type expected_reports[$];

   logic [TIMER_BITS-1:0] timeout_setting = TIMEOUT_RESET;
   logic [COUNT_BITS-1:0] source_setting = COUNT_RESET;

   logic [2:0] held_last;
   logic [TIMER_BITS-1:0] window_left;
   logic [CLICK_BITS-1:0] tap_tally;
   logic [SOURCE_BITS-1:0] source_sel;
   logic print_on;

   int polls_issued = 0;
   int polls_answered = 0;
   int error_count = 0;
   int quiet_cycles = 0;
   int hold_left = 0;
   bit hold_done = 1'b0;
   bit steady_flow = 1'b0;

   button_click_command_controller_unit i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_word(req_word),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_word(rsp_word),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic rsp_word_type poll_buttons(input req_word_type w);
      logic [2:0] held;
      logic [2:0] released;
      logic [COUNT_BITS-1:0] span;
      logic [SOURCE_BITS:0] bumped;
      logic finished;
      rsp_word_type r;
      if (w.print_begin) print_on = 1'b1;
      if (w.print_end) print_on = 1'b0;
      held = {~w.next_level, ~w.enter_level, ~w.prev_level};
      released = held_last & ~held;
      held_last = held;
      window_left = (window_left > w.elapsed_ms) ? window_left - w.elapsed_ms : '0;
      finished = 1'b0;
      if (released[1]) begin
         if (tap_tally != CLICKS_MAX) tap_tally = tap_tally + 1'b1;
         window_left = timeout_setting;
      end else if (window_left == '0 && !held[1]) begin
         finished = 1'b1;
      end
      span = (source_setting == '0) ? COUNT_BITS'(1) : source_setting;
      r.command = CMD_NONE;
      if (!print_on) begin
         if (released[0]) begin
            source_sel = (source_sel == '0) ? SOURCE_BITS'(span - 1'b1) : source_sel - 1'b1;
         end
         if (released[2]) begin
            bumped = {1'b0, source_sel} + 1'b1;
            source_sel = (bumped >= {1'b0, span}) ? '0 : bumped[SOURCE_BITS-1:0];
         end
         if (finished && tap_tally == CLICKS_ONE) r.command = CMD_INFO;
         if (finished && tap_tally == CLICKS_TWO) r.command = CMD_START;
      end else if (finished && tap_tally == CLICKS_TWO) begin
         r.command = CMD_CANCEL;
      end
      if (finished) begin
         tap_tally = '0;
         window_left = '0;
      end
      r.source_index = source_sel;
      r.printing = print_on;
      return r;
   endfunction

   task automatic note_mismatch(input string what, input int want, input int got);
      error_count++;
      if (error_count <= PRINT_CAP) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      end
   endtask

   task automatic add_poll(input int p, input int e, input int n,
                           input int ms, input int b, input int f);
      req_word_type w;
      w.prev_level = p[0];
      w.enter_level = e[0];
      w.next_level = n[0];
      w.elapsed_ms = ms[TIMER_BITS-1:0];
      w.print_begin = b[0];
      w.print_end = f[0];
      poll_queue.push_back(w);
      polls_issued++;
   endtask

   task automatic program_csr(input logic [CSR_INDEX_BITS-1:0] idx,
                              input logic [CSR_DATA_BITS-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_CLICK_TIMEOUT) timeout_setting = value;
      else if (idx == CSR_SOURCE_COUNT) source_setting = value[COUNT_BITS-1:0];
   endtask

   task automatic settle();
      while (polls_answered < polls_issued) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic queue_directed();
      add_poll(1, 1, 1, 0, 0, 0);
      add_poll(1, 0, 1, 16'hFFFF, 0, 0);
      add_poll(1, 1, 1, 0, 0, 0);
      add_poll(1, 1, 1, 499, 0, 0);
      add_poll(1, 1, 1, 1, 0, 0);
      add_poll(1, 0, 1, 10, 0, 0);
      add_poll(1, 1, 1, 10, 0, 0);
      add_poll(1, 0, 1, 10, 0, 0);
      add_poll(1, 1, 1, 10, 0, 0);
      add_poll(1, 1, 1, 16'hFFFF, 0, 0);
      add_poll(1, 0, 1, 5, 1, 0);
      add_poll(1, 1, 1, 5, 0, 0);
      add_poll(1, 0, 1, 5, 0, 0);
      add_poll(1, 1, 1, 5, 0, 0);
      add_poll(1, 1, 1, 600, 0, 0);
      add_poll(0, 1, 0, 3, 0, 0);
      add_poll(1, 1, 1, 3, 0, 0);
      add_poll(0, 0, 0, 3, 1, 1);
      add_poll(1, 1, 1, 3, 0, 0);
      add_poll(1, 0, 1, 3, 0, 0);
      add_poll(1, 1, 1, 3, 0, 0);
      add_poll(1, 0, 1, 3, 0, 0);
      add_poll(1, 1, 1, 3, 0, 0);
      add_poll(1, 1, 1, 16'hFFFF, 0, 0);
   endtask

   task automatic queue_random(input int n);
      int goal;
      int roll;
      int gap;
      bit prev_hit;
      bit next_hit;
      goal = polls_issued + n;
      while (polls_issued < goal) begin
         roll = $urandom_range(99);
         gap = timeout_setting >> 2;
         if (roll < 15) begin
            add_poll($urandom_range(1), $urandom_range(1), $urandom_range(1), $urandom(),
                     $urandom_range(7) == 0, $urandom_range(7) == 0);
         end else if (roll < 35) begin
            prev_hit = 1'($urandom_range(1));
            next_hit = !prev_hit || $urandom_range(3) == 0;
            add_poll(!prev_hit, 1, !next_hit, $urandom_range(gap), $urandom_range(15) == 0, 0);
            add_poll(1, 1, 1, $urandom_range(gap), 0, $urandom_range(15) == 0);
         end else begin
            add_poll(1, 1, 1, $urandom_range(gap),
                     $urandom_range(9) == 0, $urandom_range(9) == 0);
            repeat ($urandom_range(1, 4)) begin
               repeat ($urandom_range(1, 2)) add_poll(1, 0, 1, $urandom_range(gap), 0, 0);
               add_poll(1, 1, 1, $urandom_range(gap), 0, 0);
            end
            add_poll(1, 1, 1, $urandom_range(timeout_setting, 16'hFFFF), 0, 0);
         end
      end
   endtask

   // driver: one poll word per handshake
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         held_last = '0;
         window_left = '0;
         tap_tally = '0;
         source_sel = '0;
         print_on = 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            expected_reports.push_back(poll_buttons(req_word));
         end
         if (!req_valid || req_ready) begin
            if (poll_queue.size() > 0 && (steady_flow || $urandom_range(99) >= 33)) begin
               req_valid <= 1'b1;
               req_word <= poll_queue.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: compare each report word with the oldest prediction
   always @(posedge clock) begin : monitor_blk
      rsp_word_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            polls_answered++;
            if (expected_reports.size() == 0) begin
               note_mismatch("unexpected report word", -1, rsp_word);
            end else begin
               want = expected_reports.pop_front();
               if (want.command !== rsp_word.command) begin
                  note_mismatch("command", want.command, rsp_word.command);
               end
               if (want.source_index !== rsp_word.source_index) begin
                  note_mismatch("source_index", want.source_index, rsp_word.source_index);
               end
               if (want.printing !== rsp_word.printing) begin
                  note_mismatch("printing", want.printing, rsp_word.printing);
               end
            end
         end
         if (!hold_done && polls_answered == HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= steady_flow || $urandom_range(99) >= 33;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("button_click_command_controller_unit_tb failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      queue_directed();
      settle();

      program_csr(CSR_CLICK_TIMEOUT, 16'hFFFF);
      program_csr(CSR_SOURCE_COUNT, 16'd255);
      queue_random(350);
      settle();

      program_csr(CSR_CLICK_TIMEOUT, 16'd1);
      program_csr(CSR_SOURCE_COUNT, 16'd3);
      queue_random(200);
      settle();

      program_csr(CSR_CLICK_TIMEOUT, 16'd0);
      program_csr(CSR_SOURCE_COUNT, 16'd0);
      queue_random(150);
      settle();

      program_csr(CSR_CLICK_TIMEOUT, 16'($urandom_range(20, 2000)));
      program_csr(CSR_SOURCE_COUNT, 16'($urandom_range(1, 255)));
      steady_flow = 1'b1;
      queue_random(250);
      settle();
      steady_flow = 1'b0;

      program_csr(CSR_CLICK_TIMEOUT, 16'($urandom_range(1, 65535)));
      program_csr(CSR_SOURCE_COUNT, 16'($urandom_range(1, 255)));
      queue_random(330);
      settle();

      if (error_count == 0 && expected_reports.size() == 0) begin
         $display("button_click_command_controller_unit_tb passed");
      end else begin
         $display("button_click_command_controller_unit_tb failed");
      end
      $finish;
   end

endmodule
